// ===== hw/rtl/dcp_pkg.sv =====
// Package for the duty command parser: status codes, field widths, constants
// and the struct passed from the parser to the result stage. No dependencies.
`default_nettype none

package dcp_pkg;

   localparam int MOTOR_COUNT_DEFAULT = 2;

   localparam int BYTE_W   = 8;
   localparam int STATUS_W = 2;
   localparam int DUTY_W   = 8;
   localparam int REV_W    = 7;

   localparam logic [BYTE_W-1:0] CHAR_PERCENT = 8'h25;
   localparam logic [BYTE_W-1:0] CHAR_ZERO    = 8'h30;
   localparam logic [BYTE_W-1:0] CHAR_ONE     = 8'h31;
   localparam logic [BYTE_W-1:0] CHAR_NINE    = 8'h39;

   localparam logic [DUTY_W-1:0] DUTY_MID = 8'd100;

   typedef enum logic [STATUS_W-1:0] {
      ST_NOMATCH    = 2'd0,
      ST_INCOMPLETE = 2'd1,
      ST_COMPLETE   = 2'd2
   } status_type;

   typedef struct packed {
      status_type        status;
      logic [DUTY_W-1:0] duty0;   // motor 0 duty after this byte's update
   } parse_result_type;

endpackage

`default_nettype wire

// ===== hw/rtl/dcp_parser.sv =====
// Parser state machine and per-motor duty store for the duty command parser.
// Depends on dcp_pkg.
`default_nettype none

module dcp_parser #(
   parameter int MOTOR_COUNT = dcp_pkg::MOTOR_COUNT_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          step,
   input  wire logic [dcp_pkg::BYTE_W-1:0]    data_byte,
   output dcp_pkg::parse_result_type          result
);
   import dcp_pkg::*;

   typedef enum logic [1:0] {
      PH_IDLE  = 2'd0,
      PH_COUNT = 2'd1,
      PH_MOTOR = 2'd2,
      PH_DUTY  = 2'd3
   } phase_type;

   phase_type          phase_ff, phase_in;
   logic [3:0]         remain_ff, remain_in;
   logic [3:0]         motor_ff, motor_in;
   logic [DUTY_W-1:0]  acc_ff, acc_in;
   logic [DUTY_W-1:0]  stored_ff [MOTOR_COUNT];
   status_type         status;
   logic               is_digit;
   logic [3:0]         digit;

   assign is_digit = (data_byte >= CHAR_ZERO) && (data_byte <= CHAR_NINE);
   assign digit    = 4'(data_byte - CHAR_ZERO);

   always_comb begin
      phase_in  = phase_ff;
      remain_in = remain_ff;
      motor_in  = motor_ff;
      acc_in    = acc_ff;
      status    = ST_NOMATCH;
      case (phase_ff)
         PH_IDLE: begin
            if (data_byte == CHAR_PERCENT) begin
               phase_in = PH_COUNT;
               status   = ST_INCOMPLETE;
            end
         end
         PH_COUNT: begin
            if (data_byte >= CHAR_ONE && data_byte <= CHAR_NINE) begin
               remain_in = digit;
               phase_in  = PH_MOTOR;
               status    = ST_INCOMPLETE;
            end
         end
         PH_MOTOR: begin
            if (is_digit) begin
               motor_in  = digit;
               remain_in = remain_ff - 4'd1;
               acc_in    = '0;
               phase_in  = PH_DUTY;
               status    = ST_INCOMPLETE;
            end
         end
         default: begin
            if (is_digit && remain_ff != 4'd0) begin
               remain_in = remain_ff - 4'd1;
               acc_in    = DUTY_W'(16'(acc_ff) * 16'd10 + 16'(digit));
               status    = (remain_in == 4'd0) ? ST_COMPLETE : ST_INCOMPLETE;
            end
         end
      endcase
      if (status == ST_NOMATCH || status == ST_COMPLETE)
         phase_in = PH_IDLE;
   end

   // Completion only happens in the duty phase, so motor_ff is the command's motor.
   always_comb begin
      result.status = status;
      result.duty0  = stored_ff[0];
      if (status == ST_COMPLETE && motor_ff == 4'd0)
         result.duty0 = acc_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         remain_ff <= '0;
         motor_ff  <= '0;
         acc_ff    <= '0;
         for (int i = 0; i < MOTOR_COUNT; i++)
            stored_ff[i] <= '0;
      end else if (step) begin
         phase_ff  <= phase_in;
         remain_ff <= remain_in;
         motor_ff  <= motor_in;
         acc_ff    <= acc_in;
         // motors beyond the store are dropped
         for (int i = 0; i < MOTOR_COUNT; i++)
            if (status == ST_COMPLETE && motor_ff == 4'(i))
               stored_ff[i] <= acc_in;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/dcp_drive.sv =====
// Result stage: maps motor 0 duty to the two PWM channel values and holds the
// result register for the rsp_ channel. Depends on dcp_pkg.
`default_nettype none

module dcp_drive (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          load,
   input  wire dcp_pkg::parse_result_type     result,
   input  wire logic                          payload_end,
   output logic                               can_load,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [dcp_pkg::STATUS_W-1:0]       rsp_match_status,
   output logic                               rsp_drive_valid,
   output logic [dcp_pkg::DUTY_W-1:0]         rsp_forward_drive,
   output logic [dcp_pkg::REV_W-1:0]          rsp_reverse_drive,
   output logic                               rsp_direction_forward
);
   import dcp_pkg::*;

   logic                valid_ff;
   logic [STATUS_W-1:0] status_ff;
   logic                dvalid_ff, dvalid_in;
   logic [DUTY_W-1:0]   fwd_ff, fwd_in;
   logic [REV_W-1:0]    rev_ff, rev_in;
   logic                dir_ff, dir_in;

   assign can_load = !valid_ff || rsp_ready;

   always_comb begin
      dvalid_in = payload_end;
      fwd_in    = '0;
      rev_in    = '0;
      dir_in    = 1'b0;
      if (payload_end) begin
         if (result.duty0 > DUTY_MID) begin
            fwd_in = result.duty0 - DUTY_MID;
            dir_in = 1'b1;
         end else begin
            rev_in = REV_W'(DUTY_MID - result.duty0);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         valid_ff <= 1'b0;
      end
      if (load) begin
         status_ff <= result.status;
         dvalid_ff <= dvalid_in;
         fwd_ff    <= fwd_in;
         rev_ff    <= rev_in;
         dir_ff    <= dir_in;
      end
   end

   assign rsp_valid             = valid_ff;
   assign rsp_match_status      = status_ff;
   assign rsp_drive_valid       = dvalid_ff;
   assign rsp_forward_drive     = fwd_ff;
   assign rsp_reverse_drive     = rev_ff;
   assign rsp_direction_forward = dir_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/duty_command_parser_motor_drive.sv =====
// Top level of the duty command parser with motor drive output.
// Depends on dcp_pkg, dcp_parser and dcp_drive.
//
// Usage:
//   req_ channel carries one payload byte per transaction (req_data_byte) and
//   req_payload_end, set on the last byte of a payload. Each transaction
//   yields exactly one rsp_ transaction: the parser status for that byte and,
//   when payload_end was set, the PWM values derived from motor 0's duty.
//   Commands are '%', a count digit 1-9, a motor digit, then count-1 duty
//   digits; duties for motors at or above MOTOR_COUNT are dropped.
// Timing: a byte in the input register is parsed and its result loaded into
//   the result register, which raises rsp_valid, once that register can load.
// Throughput: one transaction per cycle while rsp_ready is high; the parse
//   step is one registered update of phase, count, accumulator and duty store.
// Reset: synchronous, clears the parser to idle, all stored duties to zero
//   and both pipeline registers to empty.
// Stall: when rsp_ready is low the result register holds; the input register
//   still takes one more byte, after which req_ready drops until the result
//   is taken.
`default_nettype none

module duty_command_parser_motor_drive #(
   parameter int MOTOR_COUNT = dcp_pkg::MOTOR_COUNT_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [dcp_pkg::BYTE_W-1:0]    req_data_byte,
   input  wire logic                          req_payload_end,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [dcp_pkg::STATUS_W-1:0]       rsp_match_status,
   output logic                               rsp_drive_valid,
   output logic [dcp_pkg::DUTY_W-1:0]         rsp_forward_drive,
   output logic [dcp_pkg::REV_W-1:0]          rsp_reverse_drive,
   output logic                               rsp_direction_forward
);
   import dcp_pkg::*;

   logic              in_valid_ff;
   logic [BYTE_W-1:0] in_byte_ff;
   logic              in_end_ff;
   logic              can_load;
   logic              advance;
   parse_result_type  result;

   assign advance   = in_valid_ff && can_load;
   assign req_ready = !in_valid_ff || can_load;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
      if (req_valid && req_ready) begin
         in_byte_ff <= req_data_byte;
         in_end_ff  <= req_payload_end;
      end
   end

   dcp_parser #(
      .MOTOR_COUNT (MOTOR_COUNT)
   ) u_parser (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .data_byte (in_byte_ff),
      .result    (result)
   );

   dcp_drive u_drive (
      .clock                 (clock),
      .reset                 (reset),
      .load                  (advance),
      .result                (result),
      .payload_end           (in_end_ff),
      .can_load              (can_load),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_match_status      (rsp_match_status),
      .rsp_drive_valid       (rsp_drive_valid),
      .rsp_forward_drive     (rsp_forward_drive),
      .rsp_reverse_drive     (rsp_reverse_drive),
      .rsp_direction_forward (rsp_direction_forward)
   );

endmodule

`default_nettype wire

// ===== hw/rtl/dcp_checker.sv =====
// Port-level checks for duty_command_parser_motor_drive, bound to the top level.
// Depends on dcp_pkg.
`default_nettype none

module dcp_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_ready,
   input wire logic [dcp_pkg::STATUS_W-1:0]  rsp_match_status,
   input wire logic                          rsp_drive_valid,
   input wire logic [dcp_pkg::DUTY_W-1:0]    rsp_forward_drive,
   input wire logic [dcp_pkg::REV_W-1:0]     rsp_reverse_drive,
   input wire logic                          rsp_direction_forward
);
   import dcp_pkg::*;

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_match_status == ST_NOMATCH ||
                     rsp_match_status == ST_INCOMPLETE ||
                     rsp_match_status == ST_COMPLETE))
      else $error("bad match status");

   a_idle_drive: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_drive_valid) |->
         (rsp_forward_drive == '0 && rsp_reverse_drive == '0 && !rsp_direction_forward))
      else $error("drive fields set without payload end");

   a_one_channel: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_direction_forward ? (rsp_reverse_drive == '0)
                                           : (rsp_forward_drive == '0)))
      else $error("both PWM channels driven");

   a_reverse_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_drive_valid && !rsp_direction_forward) |->
         (REV_W'(rsp_reverse_drive) <= REV_W'(DUTY_MID)))
      else $error("reverse drive above 100");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_match_status) && $stable(rsp_forward_drive) &&
          $stable(rsp_reverse_drive)))
      else $error("stalled result changed");

endmodule

bind duty_command_parser_motor_drive dcp_checker u_dcp_checker (
   .clock                 (clock),
   .reset                 (reset),
   .rsp_valid             (rsp_valid),
   .rsp_ready             (rsp_ready),
   .rsp_match_status      (rsp_match_status),
   .rsp_drive_valid       (rsp_drive_valid),
   .rsp_forward_drive     (rsp_forward_drive),
   .rsp_reverse_drive     (rsp_reverse_drive),
   .rsp_direction_forward (rsp_direction_forward)
);

`default_nettype wire
